// ----- hdl/iceg_pkg.sv -----
// Package for the ICMP error packet generator.
// Holds the job descriptor type, fixed constants and the checksum and type helpers.
// No dependencies.
package iceg_pkg;

	localparam int TAIL_BYTES = 8;
	localparam int XLEN_W     = 7;

	localparam logic [1:0] CFG_SRC_ADDR  = 2'd0;
	localparam logic [1:0] CFG_ICMP_TYPE = 2'd1;
	localparam logic [1:0] CFG_ICMP_CODE = 2'd2;

	localparam logic [7:0] TYPE_UNREACH  = 8'd3;
	localparam logic [7:0] TYPE_QUENCH   = 8'd4;
	localparam logic [7:0] TYPE_REDIRECT = 8'd5;
	localparam logic [7:0] TYPE_TIMEX    = 8'd11;
	localparam logic [7:0] TYPE_PARAM    = 8'd12;

	localparam logic [7:0] OPT_EOL  = 8'd0;
	localparam logic [7:0] OPT_NOP  = 8'd1;
	localparam logic [7:0] OPT_LSRR = 8'd131;
	localparam logic [7:0] OPT_SSRR = 8'd137;

	localparam logic [7:0] IP_TTL   = 8'd200;
	localparam logic [7:0] PROTO_ICMP = 8'd1;

	typedef struct packed {
		logic              bank;
		logic [XLEN_W-1:0] xlen;
		logic [31:0]       src;
		logic [7:0]        ptr;
		logic [31:0]       gw;
		logic [23:0]       psum;
	} job_t;

	function automatic logic err_type(input logic [7:0] t);
		return (t == TYPE_UNREACH) || (t == TYPE_QUENCH) || (t == TYPE_REDIRECT) ||
			(t == TYPE_TIMEX) || (t == TYPE_PARAM);
	endfunction

	function automatic logic [15:0] fold16(input logic [24:0] s);
		logic [16:0] s1;
		logic [15:0] s2;
		s1 = {1'b0, s[15:0]} + {8'b0, s[24:16]};
		s2 = s1[15:0] + {15'b0, s1[16]};
		return ~s2;
	endfunction

endpackage

// ----- hdl/iceg_fifo.sv -----
// Two-entry job queue between capture front and emit back.
// Depends on iceg_pkg.
module iceg_fifo
	import iceg_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output job_t pop_job,
	output logic empty,
	output logic full
);

	job_t       ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign empty   = (cnt_q == 2'd0);
	assign full    = (cnt_q == 2'd2);
	assign pop_job = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) !(push && full && !pop))
		else $error("job queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) !(pop && empty))
		else $error("job queue underflow");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("job queue count out of range");

endmodule

// ----- hdl/iceg_front.sv -----
// Capture front: takes packet bytes, scans options, applies suppression rules.
// Depends on iceg_pkg; writes the capture memory held in iceg_back.
module iceg_front
	import iceg_pkg::*;
#(
	parameter int CAPTURE_BYTES = 68,
	parameter int JW            = 5
)(
	input  logic          clk,
	input  logic          arst_n,
	input  logic [31:0]   src_addr,
	input  logic [7:0]    icmp_type,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [47:0]   s_tdata,
	input  logic          s_tlast,
	input  logic          s_tuser,
	input  logic [1:0]    bank_free,
	output logic          push,
	output job_t          job,
	output logic          wr_en,
	output logic [JW:0]   wr_addr,
	output logic [1:0]    wr_lane,
	output logic [7:0]    wr_data
);

	logic [15:0] cnt_q;
	logic [3:0]  hl_q;
	logic [23:0] psum_q;
	logic [6:0]  next_q;
	logic        route_q;
	logic        done_q;
	logic        wbank_q;
	logic [7:0]  hdr_q [20];
	logic [7:0]  hlb_q;

	logic        acc;
	logic [7:0]  b;
	logic [15:0] i;
	logic [3:0]  hl_nib;
	logic [5:0]  hl4;
	logic [15:0] hl4w;
	logic        in_cap;
	logic [23:0] psum_nx;
	logic [6:0]  next_nx;
	logic        route_nx;
	logic        done_nx;
	logic [15:0] len;
	logic [7:0]  b19;
	logic [7:0]  hlb;
	logic [31:0] src;
	logic [31:0] dst;
	logic        drop;
	logic [15:0] x1;
	logic [15:0] x2;
	logic [8:0]  nsum;

	assign acc      = s_tvalid && s_tready;
	assign s_tready = bank_free[wbank_q];
	assign b        = s_tdata[7:0];
	assign i        = cnt_q;
	assign hl_nib   = (i == 16'd0) ? b[3:0] : hl_q;
	assign hl4      = {hl_nib, 2'b00};
	assign hl4w     = {10'b0, hl4};
	assign in_cap   = i < 16'(CAPTURE_BYTES);

	assign wr_en   = acc && in_cap;
	assign wr_addr = {wbank_q, i[JW+1:2]};
	assign wr_lane = i[1:0];
	assign wr_data = b;

	always_comb begin
		psum_nx = psum_q;
		if (in_cap && (i < hl4w + 16'(TAIL_BYTES))) begin
			psum_nx = psum_q + (i[0] ? {16'b0, b} : {8'b0, b, 8'b0});
		end
	end

	assign nsum = {2'b0, next_q} + {1'b0, b};

	always_comb begin
		next_nx  = next_q;
		route_nx = route_q;
		done_nx  = done_q;
		if (!done_q) begin
			if (i == {9'b0, next_q}) begin
				if ((i >= hl4w) || !in_cap) begin
					done_nx = 1'b1;
				end else if ((b == OPT_LSRR) || (b == OPT_SSRR)) begin
					route_nx = 1'b1;
					done_nx  = 1'b1;
				end else if (b == OPT_EOL) begin
					done_nx = 1'b1;
				end else if (b == OPT_NOP) begin
					next_nx = i[6:0] + 7'd1;
				end
			end else if (i == {9'b0, next_q} + 16'd1) begin
				if ((b < 8'd2) || (nsum >= {3'b0, hl4})) begin
					done_nx = 1'b1;
				end else begin
					next_nx = nsum[6:0];
				end
			end
		end
	end

	assign len = (i < 16'hffff) ? i + 16'd1 : i;
	assign b19 = (i == 16'd19) ? b : hdr_q[19];
	assign hlb = (i == hl4w) ? b : hlb_q;
	assign src = {hdr_q[12], hdr_q[13], hdr_q[14], hdr_q[15]};
	assign dst = {hdr_q[16], hdr_q[17], hdr_q[18], b19};

	always_comb begin
		drop = 1'b0;
		if ((src_addr == 32'd0) || !err_type(icmp_type) || (len < 16'd20)) drop = 1'b1;
		if ((hdr_q[9] == PROTO_ICMP) && ((hl4w + 16'd4 > len) ||
			((hl4w < 16'(CAPTURE_BYTES)) && err_type(hlb)))) drop = 1'b1;
		if ((dst == 32'hffffffff) || (dst[31:28] == 4'he)) drop = 1'b1;
		if (s_tuser) drop = 1'b1;
		if ((src == 32'hffffffff) || (src[31:28] == 4'he) || (src[31:24] == 8'd0) ||
			(src[31:24] == 8'd127) || (src[31:28] == 4'hf)) drop = 1'b1;
		if ({hdr_q[6][4:0], hdr_q[7]} != 13'd0) drop = 1'b1;
		if ((icmp_type == TYPE_REDIRECT) && route_nx) drop = 1'b1;
	end

	assign x1 = (len < hl4w + 16'(TAIL_BYTES)) ? len : hl4w + 16'(TAIL_BYTES);
	assign x2 = (x1 < 16'(CAPTURE_BYTES)) ? x1 : 16'(CAPTURE_BYTES);

	assign push      = acc && s_tlast && !drop;
	assign job.bank  = wbank_q;
	assign job.xlen  = x2[XLEN_W-1:0];
	assign job.src   = src;
	assign job.ptr   = s_tdata[15:8];
	assign job.gw    = s_tdata[47:16];
	assign job.psum  = psum_nx;

	always_ff @(posedge clk) begin
		if (acc) begin
			if (i < 16'd20) hdr_q[i[4:0]] <= b;
			if (i == hl4w) hlb_q <= b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= 16'd0;
			hl_q    <= 4'd0;
			psum_q  <= 24'd0;
			next_q  <= 7'd20;
			route_q <= 1'b0;
			done_q  <= 1'b0;
			wbank_q <= 1'b0;
		end else if (acc) begin
			if (i == 16'd0) hl_q <= b[3:0];
			if (s_tlast) begin
				cnt_q   <= 16'd0;
				psum_q  <= 24'd0;
				next_q  <= 7'd20;
				route_q <= 1'b0;
				done_q  <= 1'b0;
				if (push) wbank_q <= ~wbank_q;
			end else begin
				cnt_q   <= len;
				psum_q  <= psum_nx;
				next_q  <= next_nx;
				route_q <= route_nx;
				done_q  <= done_nx;
			end
		end
	end

endmodule

// ----- hdl/iceg_back.sv -----
// Emit back: holds the two-bank capture memory and builds the error packet words.
// Depends on iceg_pkg; takes jobs from iceg_fifo.
module iceg_back
	import iceg_pkg::*;
#(
	parameter int JW = 5
)(
	input  logic          clk,
	input  logic          arst_n,
	input  logic [31:0]   src_addr,
	input  logic [7:0]    icmp_type,
	input  logic [7:0]    icmp_code,
	input  logic          wr_en,
	input  logic [JW:0]   wr_addr,
	input  logic [1:0]    wr_lane,
	input  logic [7:0]    wr_data,
	input  logic          q_empty,
	input  job_t          q_job,
	output logic          pop,
	output logic          done,
	output logic          done_bank,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [71:0]   m_tdata,
	output logic          m_tlast
);

	localparam int DEPTH = 2 ** (JW + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SUM  = 3'd1;
	localparam logic [2:0] ST_FOLD = 3'd2;
	localparam logic [2:0] ST_RD   = 3'd3;
	localparam logic [2:0] ST_WR   = 3'd4;

	logic [7:0]  cap_mem [4][DEPTH];
	logic [7:0]  rd_q [4];

	logic [2:0]  st_q;
	job_t        job_q;
	logic [15:0] id_q;
	logic [4:0]  k_q;
	logic [19:0] ipsum_q;
	logic [24:0] icsum_q;
	logic [15:0] ipck_q;
	logic [15:0] icck_q;

	logic [31:0] word_q;
	logic [2:0]  nb_q;
	logic        last_q;
	logic [31:0] dest_q;
	logic        vld_q;

	logic [7:0]  total;
	logic [5:0]  nres;
	logic [31:0] w6;
	logic [4:0]  j;
	logic [31:0] wd;
	logic [7:0]  rem;
	logic [2:0]  nb;
	logic        is_last;
	logic        slot;
	logic [7:0]  o;

	assign total = 8'd28 + {1'b0, job_q.xlen};
	assign nres  = 6'((total + 8'd3) >> 2);
	assign j     = k_q - 5'd7;
	assign slot  = !vld_q || m_tready;
	assign rem   = total - {1'b0, k_q, 2'b00};
	assign nb    = (rem >= 8'd4) ? 3'd4 : rem[2:0];
	assign is_last = ({1'b0, k_q} + 6'd1 == nres);

	always_comb begin
		w6 = 32'd0;
		if (icmp_type == TYPE_REDIRECT) w6 = job_q.gw;
		else if ((icmp_type == TYPE_PARAM) && (icmp_code == 8'd0)) w6 = {job_q.ptr, 24'd0};
	end

	always_comb begin
		o = 8'd0;
		wd = 32'd0;
		case (k_q)
			5'd0: wd = {8'h45, 8'h00, 8'h00, total};
			5'd1: wd = {id_q, 16'h0000};
			5'd2: wd = {IP_TTL, PROTO_ICMP, ipck_q};
			5'd3: wd = src_addr;
			5'd4: wd = job_q.src;
			5'd5: wd = {icmp_type, icmp_code, icck_q};
			5'd6: wd = w6;
			default: begin
				for (int m = 0; m < 4; m++) begin
					o = {1'b0, k_q, 2'b00} + 8'(m);
					wd[31-8*m -: 8] = (o < total) ? rd_q[m] : 8'd0;
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) cap_mem[wr_lane][wr_addr] <= wr_data;
		for (int m = 0; m < 4; m++) begin
			rd_q[m] <= cap_mem[m][{job_q.bank, j[JW-1:0]}];
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && !q_empty) job_q <= q_job;
		if (st_q == ST_SUM) begin
			ipsum_q <= 20'h4500 + {12'b0, total} + {4'b0, id_q} + 20'hc801 +
				{4'b0, src_addr[31:16]} + {4'b0, src_addr[15:0]} +
				{4'b0, job_q.src[31:16]} + {4'b0, job_q.src[15:0]};
			icsum_q <= {1'b0, job_q.psum} + {9'b0, icmp_type, icmp_code} +
				{9'b0, w6[31:16]} + {9'b0, w6[15:0]};
		end
		if (st_q == ST_FOLD) begin
			ipck_q <= fold16({5'b0, ipsum_q});
			icck_q <= fold16(icsum_q);
		end
		if (st_q == ST_WR && slot) begin
			word_q <= wd;
			nb_q   <= nb;
			last_q <= is_last;
			dest_q <= job_q.src;
		end
	end

	assign pop       = (st_q == ST_IDLE) && !q_empty;
	assign done      = (st_q == ST_WR) && slot && is_last;
	assign done_bank = job_q.bank;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_IDLE;
			id_q  <= 16'd1;
			k_q   <= 5'd0;
			vld_q <= 1'b0;
		end else begin
			if (m_tready) vld_q <= 1'b0;
			case (st_q)
				ST_IDLE: if (!q_empty) st_q <= ST_SUM;
				ST_SUM:  st_q <= ST_FOLD;
				ST_FOLD: begin
					k_q  <= 5'd0;
					st_q <= ST_RD;
				end
				ST_RD:   st_q <= ST_WR;
				ST_WR: begin
					if (slot) begin
						vld_q <= 1'b1;
						if (is_last) begin
							id_q <= id_q + 16'd1;
							st_q <= ST_IDLE;
						end else begin
							k_q  <= k_q + 5'd1;
							st_q <= ST_RD;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = vld_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {5'b0, dest_q, nb_q, word_q};

	a_bytes_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[34:32] != 3'd0) && (m_tdata[34:32] <= 3'd4))
		else $error("word byte count out of range");
	a_short_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[34:32] != 3'd4)) |-> m_tlast)
		else $error("partial word before end of packet");

endmodule

// ----- hdl/icmp_error_packet_generator.sv -----
// ICMP error packet generator, top level: configuration registers and bank tracking.
// Depends on iceg_pkg, iceg_front, iceg_fifo, iceg_back.
//
// Packet bytes are taken one per cycle while a capture bank is free. Two banks
// let one packet be captured while the error for the previous one is sent.
// After the last byte the emitter runs a checksum setup (sum, then fold), then
// for each output word a memory read and then the output register, stalling
// while m_tready holds the output; s_tready drops only when both banks hold
// packets still waiting to be sent.
module icmp_error_packet_generator
	import iceg_pkg::*;
#(
	parameter int CAPTURE_BYTES = 68
)(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // pkt_byte[7:0], param_pointer[15:8], gateway_addr[47:16]
	input  logic        s_tlast,
	input  logic        s_tuser,   // mac_bcast
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // out_word[31:0], out_bytes[34:32], out_dest_addr[66:35]
	output logic        m_tlast
);

	localparam int WORDS = (CAPTURE_BYTES + 3) / 4;
	localparam int JW    = $clog2(WORDS);

	logic [31:0] src_addr_q;
	logic [7:0]  icmp_type_q;
	logic [7:0]  icmp_code_q;
	logic [1:0]  busy_q;

	logic        push;
	job_t        push_job;
	logic        pop;
	job_t        pop_job;
	logic        q_empty;
	logic        q_full;
	logic        done;
	logic        done_bank;
	logic        wr_en;
	logic [JW:0] wr_addr;
	logic [1:0]  wr_lane;
	logic [7:0]  wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_addr_q  <= 32'd0;
			icmp_type_q <= TYPE_UNREACH;
			icmp_code_q <= 8'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SRC_ADDR:  src_addr_q  <= cfg_data;
				CFG_ICMP_TYPE: icmp_type_q <= cfg_data[7:0];
				CFG_ICMP_CODE: icmp_code_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 2'b00;
		end else begin
			for (int n = 0; n < 2; n++) begin
				if (push && (push_job.bank == 1'(n))) busy_q[n] <= 1'b1;
				else if (done && (done_bank == 1'(n))) busy_q[n] <= 1'b0;
			end
		end
	end

	iceg_front #(.CAPTURE_BYTES(CAPTURE_BYTES), .JW(JW)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_addr  (src_addr_q),
		.icmp_type (icmp_type_q),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.s_tuser   (s_tuser),
		.bank_free (~busy_q),
		.push      (push),
		.job       (push_job),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_lane   (wr_lane),
		.wr_data   (wr_data)
	);

	iceg_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.pop_job  (pop_job),
		.empty    (q_empty),
		.full     (q_full)
	);

	iceg_back #(.JW(JW)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_addr  (src_addr_q),
		.icmp_type (icmp_type_q),
		.icmp_code (icmp_code_q),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_lane   (wr_lane),
		.wr_data   (wr_data),
		.q_empty   (q_empty),
		.q_job     (pop_job),
		.pop       (pop),
		.done      (done),
		.done_bank (done_bank),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	a_push_free_bank: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !busy_q[push_job.bank] && !q_full)
		else $error("job pushed into a busy bank");

endmodule

// ----- tb/sv/icmp_error_packet_generator_test.sv -----
// Self-checking testbench for icmp_error_packet_generator.
// Feeds IPv4 packets byte by byte, predicts the ICMP error words, compares them.
// Depends on iceg_pkg and the generator RTL.
module icmp_error_packet_generator_test;
	import iceg_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAP = 68;
	localparam int WATCHDOG = 20000;

	typedef struct {
		logic [7:0]  b;
		logic        last;
		logic        mac;
		logic [7:0]  ptr;
		logic [31:0] gw;
	} pkt_item_t;

	typedef struct {
		logic [31:0] word;
		logic [2:0]  nbytes;
		logic        last;
		logic [31:0] dest;
	} err_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;
	logic        m_tlast;

	icmp_error_packet_generator i_dut (.*);

	always #5 clk = ~clk;

	pkt_item_t pending_bytes[$];
	err_word_t expected_words[$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_cycles = 0;
	int quiet_cycles = 0;
	int words_seen = 0;

	// predictor state
	logic [31:0] p_src = 0;
	logic [7:0]  p_type = TYPE_UNREACH;
	logic [7:0]  p_code = 0;
	logic [7:0]  cbuf[CAP];
	int unsigned cnt = 0, pid = 1, psum = 0, onext = 20;
	bit route_seen = 0, scan_done = 0;

	function automatic bit is_err(int unsigned t);
		return t == 3 || t == 4 || t == 5 || t == 11 || t == 12;
	endfunction

	function automatic int unsigned capb(int unsigned idx);
		return (idx < cnt && idx < CAP) ? cbuf[idx] : 0;
	endfunction

	function automatic int unsigned cap_word(int unsigned idx);
		return (capb(idx) << 24) | (capb(idx + 1) << 16) | (capb(idx + 2) << 8) | capb(idx + 3);
	endfunction

	function automatic bit unicast(logic [31:0] a);
		return !(a == 32'hffffffff || a[31:28] == 4'he);
	endfunction

	function automatic int unsigned csum_fold(int unsigned s);
		while (s >> 16) s = (s & 16'hffff) + (s >> 16);
		return (~s) & 16'hffff;
	endfunction

	function automatic void clear_capture();
		cnt = 0; psum = 0; onext = 20; route_seen = 0; scan_done = 0;
	endfunction

	function automatic void predict_byte(pkt_item_t it);
		int unsigned i, b, hl4, len, xlen, total, s, nres;
		logic [31:0] src;
		logic [7:0] pk[100];
		err_word_t w;
		i = cnt; b = it.b;
		if (i < CAP) cbuf[i] = it.b;
		hl4 = ((i == 0 ? b : cbuf[0]) & 15) * 4;
		if (i < CAP && i < hl4 + TAIL_BYTES) psum += (i & 1) ? b : (b << 8);
		if (!scan_done) begin
			if (i == onext) begin
				if (i >= hl4 || i >= CAP) scan_done = 1;
				else if (b == OPT_LSRR || b == OPT_SSRR) begin
					route_seen = 1; scan_done = 1;
				end else if (b == OPT_EOL) scan_done = 1;
				else if (b == OPT_NOP) onext = i + 1;
			end else if (i == onext + 1) begin
				if (b < 2 || onext + b >= hl4) scan_done = 1;
				else onext = onext + b;
			end
		end
		cnt = (i < 16'hffff) ? i + 1 : i;
		if (!it.last) return;
		len = cnt;
		src = cap_word(12);
		if (p_src == 0 || !is_err(p_type) || len < 20 ||
				(capb(9) == 1 && (hl4 + 4 > len || is_err(capb(hl4)))) ||
				!unicast(cap_word(16)) || it.mac || !unicast(src) ||
				src[31:24] == 0 || src[31:24] == 127 || src[31:28] == 4'hf ||
				(((capb(6) << 8) | capb(7)) & 16'h1fff) != 0 ||
				(p_type == TYPE_REDIRECT && route_seen)) begin
			clear_capture();
			return;
		end
		xlen = len;
		if (xlen > hl4 + TAIL_BYTES) xlen = hl4 + TAIL_BYTES;
		if (xlen > CAP) xlen = CAP;
		total = 28 + xlen;
		foreach (pk[k]) pk[k] = 0;
		pk[0] = 8'h45; pk[2] = total >> 8; pk[3] = total;
		pk[4] = pid >> 8; pk[5] = pid; pk[8] = IP_TTL; pk[9] = PROTO_ICMP;
		for (int k = 0; k < 4; k++) begin
			pk[12 + k] = p_src >> (24 - 8 * k);
			pk[16 + k] = src >> (24 - 8 * k);
		end
		s = 0;
		for (int k = 0; k < 20; k += 2) s += (pk[k] << 8) | pk[k + 1];
		s = csum_fold(s);
		pk[10] = s >> 8; pk[11] = s;
		pk[20] = p_type; pk[21] = p_code;
		if (p_type == TYPE_PARAM && p_code == 0) pk[24] = it.ptr;
		if (p_type == TYPE_REDIRECT)
			for (int k = 0; k < 4; k++) pk[24 + k] = it.gw >> (24 - 8 * k);
		for (int k = 0; k < xlen; k++) pk[28 + k] = capb(k);
		s = psum + ((p_type << 8) | p_code) + ((pk[24] << 8) | pk[25]) + ((pk[26] << 8) | pk[27]);
		s = csum_fold(s);
		pk[22] = s >> 8; pk[23] = s;
		nres = (total + 3) / 4;
		for (int k = 0; k < nres; k++) begin
			w.word = {pk[4 * k], pk[4 * k + 1], pk[4 * k + 2], pk[4 * k + 3]};
			w.nbytes = (total - 4 * k > 4) ? 4 : total - 4 * k;
			w.last = (k + 1 == nres);
			w.dest = src;
			expected_words.push_back(w);
		end
		pid = (pid + 1) & 16'hffff;
		clear_capture();
	endfunction

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || s_tready) begin
				if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					pkt_item_t it;
					it = pending_bytes.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {it.gw, it.ptr, it.b};
					s_tlast <= it.last;
					s_tuser <= it.mac;
				end else
					s_tvalid <= 1'b0;
			end
			if (hold_cycles > 0) begin
				hold_cycles <= hold_cycles - 1;
				m_tready <= 1'b0;
			end else
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// monitor, predictor feed, watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				pkt_item_t it;
				it.b = s_tdata[7:0]; it.ptr = s_tdata[15:8]; it.gw = s_tdata[47:16];
				it.last = s_tlast; it.mac = s_tuser;
				predict_byte(it);
			end
			if (m_tvalid && m_tready) begin
				err_word_t w;
				words_seen++;
				if (expected_words.size() == 0) begin
					errors++;
					$display("%t: unexpected word %h", $time, m_tdata);
				end else begin
					w = expected_words.pop_front();
					if (m_tdata[31:0] !== w.word || m_tdata[34:32] !== w.nbytes ||
							m_tdata[66:35] !== w.dest || m_tlast !== w.last) begin
						errors++;
						$display("%t: expected word %h bytes %0d last %b dest %h, got %h %0d %b %h",
							$time, w.word, w.nbytes, w.last, w.dest, m_tdata[31:0],
							m_tdata[34:32], m_tlast, m_tdata[66:35]);
					end
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
			else quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles > WATCHDOG) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	// Builds one packet; good selects a well-formed header.
	task automatic queue_packet(int plen, bit good, int ihl, logic [7:0] proto,
			bit mac, bit rroute);
		logic [7:0] p[];
		pkt_item_t it;
		p = new[plen];
		foreach (p[k]) p[k] = $urandom;
		if (good) begin
			if (plen > 0) p[0] = {4'h4, 4'(ihl)};
			if (plen > 6) p[6] = $urandom_range(1) ? 8'h40 : 8'h00;
			if (plen > 7) p[7] = 0;
			if (plen > 9) p[9] = proto;
			if (plen > 12) p[12] = $urandom_range(1, 126);
			if (plen > 16) p[16] = $urandom_range(1, 223);
			if (plen > 20 && ihl > 5) begin
				for (int k = 20; k < plen && k < ihl * 4; k++) p[k] = OPT_NOP;
				if (rroute) begin
					p[20] = $urandom_range(1) ? OPT_LSRR : OPT_SSRR;
					if (plen > 21) p[21] = 3;
				end else if ($urandom_range(3) == 0) p[20 + $urandom_range(ihl * 4 - 21)] = $urandom;
			end
			if (proto == PROTO_ICMP && plen > ihl * 4)
				p[ihl * 4] = $urandom_range(1) ? 8'd8 : 8'($urandom);
		end
		foreach (p[k]) begin
			it.b = p[k]; it.last = (k == plen - 1); it.mac = mac;
			it.ptr = $urandom; it.gw = $urandom;
			pending_bytes.push_back(it);
		end
	endtask

	task automatic drain();
		while (pending_bytes.size() > 0 || s_tvalid || expected_words.size() > 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_SRC_ADDR:  p_src = val;
			CFG_ICMP_TYPE: p_type = val[7:0];
			default:       p_code = val[7:0];
		endcase
	endtask

	task automatic random_packets(int n);
		repeat (n) begin
			int ihl;
			ihl = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(5, 7);
			if ($urandom_range(9) < 8)
				queue_packet($urandom_range(9) == 0 ? $urandom_range(20, 80) :
						$urandom_range(20, 36), 1, ihl,
					$urandom_range(3) == 0 ? PROTO_ICMP : 8'($urandom),
					$urandom_range(15) == 0, $urandom_range(5) == 0);
			else
				queue_packet($urandom_range(1, 30), 0, 5, 0, $urandom_range(1), 0);
		end
	endtask

	initial begin
		logic [7:0] types[6];
		types = '{TYPE_UNREACH, TYPE_QUENCH, TYPE_REDIRECT, TYPE_TIMEX, TYPE_PARAM, 8'd7};
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		// unconfigured: everything absorbed
		queue_packet(28, 1, 5, 8'd17, 0, 0);
		drain();
		write_reg(CFG_SRC_ADDR, 32'hffffffff);
		write_reg(CFG_ICMP_CODE, 8'd0);
		// directed: special cases
		queue_packet(19, 1, 5, 8'd6, 0, 0);
		queue_packet(20, 1, 5, 8'd6, 0, 0);
		queue_packet(28, 1, 5, 8'd17, 1, 0);
		queue_packet(22, 1, 5, PROTO_ICMP, 0, 0);
		queue_packet(28, 1, 5, PROTO_ICMP, 0, 0);
		queue_packet(40, 1, 6, 8'd17, 0, 1);
		queue_packet(28, 1, 3, 8'd17, 0, 0);
		queue_packet(80, 1, 15, 8'd6, 0, 0);
		queue_packet(100, 1, 5, 8'd6, 0, 0);
		drain();
		foreach (types[t]) begin
			write_reg(CFG_ICMP_TYPE, types[t]);
			write_reg(CFG_ICMP_CODE, t[0] ? 8'hff : 8'd0);
			write_reg(CFG_SRC_ADDR, t == 2 ? 32'h1 : $urandom);
			queue_packet(36, 1, 6, 8'd6, 0, t == 2);
			queue_packet(60, 1, 13, 8'd6, 0, 0);
			drain();
		end
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1 || ph == 3) ? 65 : 0;
			recv_stall_pct = (ph == 2 || ph == 3) ? 65 : 0;
			if (ph == 3) begin
				send_idle_pct = 11; recv_stall_pct = 11;
			end
			write_reg(CFG_ICMP_TYPE, types[$urandom_range(4)]);
			write_reg(CFG_ICMP_CODE, $urandom_range(1) ? 8'd0 : 8'($urandom));
			write_reg(CFG_SRC_ADDR, $urandom | 1);
			random_packets(3);
			if (ph == 0) hold_cycles = 400;
			random_packets(5);
			drain();
		end
		send_idle_pct = 0; recv_stall_pct = 0;
		drain();
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
